// File: src/wfc_pkg.sv
// ----------------------------------------------------------------------------
// wfc_pkg
// Types and codes shared by the wall-follow corrector modules.
// ----------------------------------------------------------------------------
package wfc_pkg;

  localparam int DIST_BITS = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 8;
  localparam int CORR_BITS = 7;

  typedef logic [DIST_BITS-1:0] dist_t;
  typedef logic [CORR_BITS-1:0] corr_t;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_FAR_LIMIT      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NEAR_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MID_DISTANCE   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_CORRECTION = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_SPEED_B   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_SPEED_C   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_JUMP_THRESHOLD = 3'd7;

  // Reset values of the registers
  localparam logic [7:0]           RST_FAR_LIMIT      = 8'd40;
  localparam logic [7:0]           RST_NEAR_LIMIT     = 8'd20;
  localparam logic [7:0]           RST_MAX_LIMIT      = 8'd80;
  localparam logic [7:0]           RST_MID_DISTANCE   = 8'd30;
  localparam logic [CORR_BITS-1:0] RST_MAX_CORRECTION = 7'd20;
  localparam logic [6:0]           RST_BASE_SPEED_B   = 7'd70;
  localparam logic [6:0]           RST_BASE_SPEED_C   = 7'd70;
  localparam logic [7:0]           RST_JUMP_THRESHOLD = 8'd20;

  // Side of the last correction
  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_LEFT  = 2'd2;

  // Turn requests
  localparam logic [2:0] TURN_NONE        = 3'd0;
  localparam logic [2:0] TURN_RIGHT       = 3'd1;
  localparam logic [2:0] TURN_LEFT        = 3'd2;
  localparam logic [2:0] TURN_REPOS_LEFT  = 3'd3;
  localparam logic [2:0] TURN_REPOS_RIGHT = 3'd4;

  // Tone requests
  localparam logic [1:0] TONE_NONE = 2'd0;
  localparam logic [1:0] TONE_HIGH = 2'd1;
  localparam logic [1:0] TONE_LOW  = 2'd2;

  typedef struct packed {
    logic [7:0]           far_limit;
    logic [7:0]           near_limit;
    logic [7:0]           max_limit;
    logic [7:0]           mid_distance;
    logic [CORR_BITS-1:0] max_correction;
    logic [6:0]           base_speed_b;
    logic [6:0]           base_speed_c;
    logic [7:0]           jump_threshold;
  } cfg_t;

  typedef struct packed {
    dist_t previous_distance;
    dist_t earlier_distance;
    corr_t correction_b;
    corr_t correction_c;
    logic [1:0] last_side;
  } state_t;

  typedef struct packed {
    dist_t wall_distance;
    logic  bumper_pressed;
    logic  clear_history;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] speed_b;
    logic signed [7:0] speed_c;
    logic              speed_update;
    logic [2:0]        turn_request;
    logic [1:0]        tone_request;
  } out_item_t;

endpackage

// File: src/wfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// wfc_cfg_regs
// Configuration register file; one register written per handshake.
// ----------------------------------------------------------------------------
module wfc_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [wfc_pkg::CFG_IDX_BITS-1:0]     wr_index,
  input  logic [wfc_pkg::CFG_DATA_BITS-1:0]    wr_data,
  output wfc_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.far_limit      <= wfc_pkg::RST_FAR_LIMIT;
      cfg.near_limit     <= wfc_pkg::RST_NEAR_LIMIT;
      cfg.max_limit      <= wfc_pkg::RST_MAX_LIMIT;
      cfg.mid_distance   <= wfc_pkg::RST_MID_DISTANCE;
      cfg.max_correction <= wfc_pkg::RST_MAX_CORRECTION;
      cfg.base_speed_b   <= wfc_pkg::RST_BASE_SPEED_B;
      cfg.base_speed_c   <= wfc_pkg::RST_BASE_SPEED_C;
      cfg.jump_threshold <= wfc_pkg::RST_JUMP_THRESHOLD;
    end else if (wr_en) begin
      // keep only the register's own width
      unique case (wr_index)
        wfc_pkg::REG_FAR_LIMIT:      cfg.far_limit      <= wr_data;
        wfc_pkg::REG_NEAR_LIMIT:     cfg.near_limit     <= wr_data;
        wfc_pkg::REG_MAX_LIMIT:      cfg.max_limit      <= wr_data;
        wfc_pkg::REG_MID_DISTANCE:   cfg.mid_distance   <= wr_data;
        wfc_pkg::REG_MAX_CORRECTION: cfg.max_correction <= wr_data[6:0];
        wfc_pkg::REG_BASE_SPEED_B:   cfg.base_speed_b   <= wr_data[6:0];
        wfc_pkg::REG_BASE_SPEED_C:   cfg.base_speed_c   <= wr_data[6:0];
        wfc_pkg::REG_JUMP_THRESHOLD: cfg.jump_threshold <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: src/wfc_tick.sv
// ----------------------------------------------------------------------------
// wfc_tick
// Combinational decision for one tick: next state and the result word.
// ----------------------------------------------------------------------------
module wfc_tick (
  input  wfc_pkg::cfg_t      cfg,
  input  wfc_pkg::state_t    state,
  input  wfc_pkg::in_item_t  item,
  output wfc_pkg::state_t    state_next,
  output wfc_pkg::out_item_t result
);

  wfc_pkg::dist_t d;
  wfc_pkg::dist_t p;
  wfc_pkg::dist_t e;
  logic signed [wfc_pkg::DIST_BITS:0] rise;
  logic signed [wfc_pkg::DIST_BITS:0] jump;
  logic rise_neg;
  logic in_mid_band;
  logic reentry;
  logic exit_band;
  logic outward;
  logic correct;
  logic inward;
  logic jump_turn;

  // left / right correction candidates
  logic [wfc_pkg::CORR_BITS:0] left_c_wide;
  logic [wfc_pkg::CORR_BITS:0] right_b_wide;
  wfc_pkg::corr_t left_b;
  wfc_pkg::corr_t left_c;
  wfc_pkg::corr_t right_b;
  wfc_pkg::corr_t right_c;
  wfc_pkg::corr_t lim;
  wfc_pkg::corr_t new_b;
  wfc_pkg::corr_t new_c;

  assign d    = item.wall_distance;
  assign p    = state.previous_distance;
  assign e    = state.earlier_distance;
  assign lim  = cfg.max_correction;
  assign rise = $signed({1'b0, d}) - $signed({1'b0, p});
  assign jump = $signed({1'b0, cfg.jump_threshold});
  assign rise_neg = rise[wfc_pkg::DIST_BITS];

  assign in_mid_band = (d < cfg.far_limit) && (d > cfg.near_limit);
  assign reentry   = in_mid_band && (p > cfg.far_limit) && (e > cfg.far_limit);
  assign exit_band = in_mid_band && (p < cfg.near_limit) && (e < cfg.near_limit);
  assign outward   = (d < cfg.near_limit) || ((d < cfg.far_limit) && rise_neg);
  assign correct   = (d > cfg.far_limit) || outward;
  assign inward    = !rise_neg && (rise < jump) && (d < cfg.max_limit);
  assign jump_turn = (rise > jump) || (d >= cfg.max_limit);

  always_comb begin
    left_b      = state.correction_b;
    left_c_wide = {1'b0, state.correction_c};
    if (state.last_side == wfc_pkg::SIDE_RIGHT) begin
      left_b      = '0;
      left_c_wide = '0;
    end else if (state.correction_b != '0) begin
      left_b = state.correction_b - 1'b1;
    end else begin
      left_c_wide = left_c_wide + 1'b1;
    end
    left_c = (left_c_wide > {1'b0, lim}) ? lim : left_c_wide[wfc_pkg::CORR_BITS-1:0];
  end

  always_comb begin
    right_c      = state.correction_c;
    right_b_wide = {1'b0, state.correction_b};
    if (state.last_side == wfc_pkg::SIDE_LEFT) begin
      right_c      = '0;
      right_b_wide = '0;
    end else if (state.correction_c != '0) begin
      right_c = state.correction_c - 1'b1;
    end else begin
      right_b_wide = right_b_wide + 1'b1;
    end
    right_b = (right_b_wide > {1'b0, lim}) ? lim : right_b_wide[wfc_pkg::CORR_BITS-1:0];
  end

  always_comb begin
    state_next = state;
    result     = '0;
    new_b      = state.correction_b;
    new_c      = state.correction_c;
    priority if (item.clear_history) begin
      state_next.previous_distance = cfg.mid_distance;
      state_next.earlier_distance  = cfg.mid_distance;
    end else if (item.bumper_pressed) begin
      result.turn_request = wfc_pkg::TURN_LEFT;
    end else if (reentry) begin
      state_next.correction_b = '0;
      state_next.correction_c = '0;
      result.turn_request     = wfc_pkg::TURN_REPOS_LEFT;
    end else if (exit_band) begin
      state_next.correction_b = '0;
      state_next.correction_c = '0;
      result.turn_request     = wfc_pkg::TURN_REPOS_RIGHT;
    end else if (correct) begin
      state_next.earlier_distance = p;
      priority if (outward) begin
        result.tone_request  = wfc_pkg::TONE_HIGH;
        new_b                = left_b;
        new_c                = left_c;
        state_next.last_side = wfc_pkg::SIDE_LEFT;
      end else if (inward) begin
        result.tone_request  = wfc_pkg::TONE_LOW;
        new_b                = right_b;
        new_c                = right_c;
        state_next.last_side = wfc_pkg::SIDE_RIGHT;
      end else if (jump_turn) begin
        result.turn_request         = wfc_pkg::TURN_RIGHT;
        state_next.earlier_distance = cfg.mid_distance;
      end else begin
        // rise negative or equal to threshold: no nudge
      end
      state_next.correction_b      = new_b;
      state_next.correction_c      = new_c;
      state_next.previous_distance = d;
      result.speed_update          = 1'b1;
      result.speed_b = $signed({1'b0, cfg.base_speed_b}) - $signed({1'b0, new_b});
      result.speed_c = $signed({1'b0, cfg.base_speed_c}) - $signed({1'b0, new_c});
    end else begin
      state_next.correction_b = '0;
      state_next.correction_c = '0;
    end
  end

endmodule

// File: src/wall_follow_corrector.sv
// ----------------------------------------------------------------------------
// wall_follow_corrector
// Wall-following tick logic: distance history, saturating wheel corrections,
// turn and tone requests, one result word per input word.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload                        | dir
//  --------+----------------------+--------------------------------+-----
//  in      | in_valid / in_ready  | in_data   (wfc_pkg::in_item_t) | in
//  out     | out_valid / out_ready| out_data  (wfc_pkg::out_item_t)| out
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data            | in
//
//  One word per cycle sustained while out_ready stays high. An accepted word
//  sits in the input register; the tick logic and the state update work on it
//  there and load the result register when the word advances. The state
//  registers feed straight back into the tick logic, which sets the one-cycle
//  rate. Reset (rst, synchronous) reloads the configuration defaults, fills
//  the history with the default mid distance and empties both registers.
//  A stall on out_ready holds the result register; the input register still
//  takes a word while it is empty. cfg_ready is always high.
//
module wall_follow_corrector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  wfc_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output wfc_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wfc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [wfc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  wfc_pkg::cfg_t      cfg;
  wfc_pkg::state_t    state;
  wfc_pkg::state_t    state_next;
  wfc_pkg::in_item_t  item;
  wfc_pkg::out_item_t result;
  logic               item_valid;
  logic               advance;

  assign cfg_ready = 1'b1;

  wfc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  wfc_tick u_tick (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result)
  );

  // Advance the held word when the result register is free or being drained
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  // State: update only when the tick commits its result
  always_ff @(posedge clk) begin
    if (rst) begin
      state.previous_distance <= wfc_pkg::RST_MID_DISTANCE;
      state.earlier_distance  <= wfc_pkg::RST_MID_DISTANCE;
      state.correction_b      <= '0;
      state.correction_c      <= '0;
      state.last_side         <= wfc_pkg::SIDE_NONE;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: hold while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef ASSERT_OFF
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !item_valid)
    else $error("pipeline not empty after reset");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid && $stable(item))
    else $error("stalled input word lost");

  a_idle_speeds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.speed_update |->
      out_data.speed_b == 8'sd0 && out_data.speed_c == 8'sd0 &&
      out_data.tone_request == wfc_pkg::TONE_NONE)
    else $error("speeds or tone without speed update");

  a_right_turn_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.turn_request == wfc_pkg::TURN_RIGHT |->
      out_data.speed_update && out_data.tone_request == wfc_pkg::TONE_NONE)
    else $error("right turn with tone or without speed update");
`endif

endmodule
